### src/ffha_pkg.sv
// Shared types, constants and CRC helpers of the first-fit heap allocator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ffha_pkg;

    localparam int POOL_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 12;
    localparam int REQ_W            = 13;
    localparam int HANDLE_W         = 12;
    localparam int THR_W            = 4;

    localparam logic [THR_W-1:0] THR_RESET  = 4'd4;
    localparam logic [7:0]       CRC_POLY   = 8'h07;
    localparam logic [7:0]       ATTR_USED  = 8'h01;
    localparam logic [7:0]       ATTR_SLACK = 8'h02;

    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_RESIZE = 2'd2,
        REQ_BAD    = 2'd3
    } t_req_type;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NULL    = 3'd1,
        ST_NOSPACE = 3'd2,
        ST_SHRINK  = 3'd3,
        ST_FAULT   = 3'd4
    } t_status;

    // Result of the byte-serial CRC unit.
    typedef struct packed {
        logic       done;
        logic [7:0] value;
    } t_crc_rsp;

    // One byte of CRC-8, MSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Whole five-byte header check; used only for elaboration-time constants.
    function automatic logic [7:0] crc_bytes(input logic [39:0] msg);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 4; i >= 0; i--) begin
            c = crc8_byte(c, msg[i*8 +: 8]);
        end
        return c;
    endfunction

    // Replace the slack flag and slack length of an attribute byte.
    function automatic logic [7:0] set_slack(input logic [7:0] attr, input logic flag,
                                             input logic [5:0] len);
        logic [7:0] a;
        a = {len, 1'b0, attr[0]};
        if (flag) begin
            a = a | ATTR_SLACK;
        end
        return a;
    endfunction

endpackage

`default_nettype wire

### src/first_fit_heap_allocator_unit.sv
// First-fit heap allocator: request sequencer around the header store.
// Depends on ffha_pkg, ffha_mem and ffha_crc.
//
// The block manages a byte pool as an address-ordered chain of blocks whose
// headers live in one synchronous memory, one entry per pool offset. A request
// allocates, frees or resizes; each request yields exactly one response. The
// block works on one request at a time: every chain step is one memory read.
// An allocate walks the chain header by header and splits the block when
// enough is left, a free walks up to the first mergeable pair, and a resize
// grows in place, or does an allocate and a free when it moves. Each header
// checksum goes through a byte-serial CRC unit, and an address that wraps
// around the pool end is reduced by repeated subtraction, one pool length
// per cycle. Right after reset the block writes the head header before it
// takes a request.
// A finished response sits in an output register, so the sequencer only waits
// on the response side when a second response is ready before the first one
// was taken. The split threshold may be written at any time the block is idle.
`default_nettype none

module first_fit_heap_allocator_unit
    import ffha_pkg::*;
#(
    parameter int POOL_BYTES   = POOL_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [THR_W-1:0]    i_cfg_wdata,
    input  wire logic                i_req_valid,
    output logic                     o_req_ready,
    input  wire logic [1:0]          i_req_type,
    input  wire logic [HANDLE_W-1:0] i_handle,
    input  wire logic [REQ_W-1:0]    i_req_size,
    output logic                     o_rsp_valid,
    input  wire logic                i_rsp_ready,
    output logic [2:0]               o_status,
    output logic [HANDLE_W-1:0]      o_result_handle,
    output logic                     o_copy_valid,
    output logic [HANDLE_W-1:0]      o_copy_src,
    output logic [HANDLE_W-1:0]      o_copy_dst,
    output logic [REQ_W-1:0]         o_copy_len
);

    localparam int AW  = $clog2(POOL_BYTES);
    localparam int SW0 = $clog2(POOL_BYTES + 1);
    localparam int SW  = (SW0 > REQ_W) ? SW0 : REQ_W;
    localparam int XW  = SW + 1;
    localparam int HW  = SW + AW + 16;

    localparam logic [XW-1:0]   HB     = XW'(HEADER_BYTES);
    localparam logic [XW-1:0]   PB     = XW'(POOL_BYTES);
    localparam logic [AW:0]     PSTEPS = (AW + 1)'(POOL_BYTES);
    localparam logic [31:0]     INIT32 = 32'(POOL_BYTES - HEADER_BYTES);
    localparam logic [7:0]      INIT_CRC = crc_bytes({INIT32[7:0], INIT32[15:8], 24'h0});

    typedef struct packed {
        logic [SW-1:0] size;
        logic [AW-1:0] nxt;
        logic [7:0]    attr;
        logic [7:0]    crc;
    } t_hdr;

    typedef enum logic [20:0] {
        S_INIT   = 21'h000001,
        S_IDLE   = 21'h000002,
        S_L_DAT  = 21'h000004,
        S_L_CRC  = 21'h000008,
        S_R_EVAL = 21'h000010,
        S_R_J    = 21'h000020,
        S_R_SH   = 21'h000040,
        S_R_CW   = 21'h000080,
        S_R_MOVE = 21'h000100,
        S_A_ISS  = 21'h000200,
        S_A_CHK  = 21'h000400,
        S_A_SPL  = 21'h000800,
        S_A_C1   = 21'h001000,
        S_A_C2   = 21'h002000,
        S_F_RD   = 21'h004000,
        S_F_MOD  = 21'h008000,
        S_F_W0   = 21'h010000,
        S_F_I    = 21'h020000,
        S_F_J    = 21'h040000,
        S_WRAP   = 21'h080000,
        S_DONE   = 21'h100000
    } t_state;

    // The message bytes are size low, size high, next low, next high, attribute.
    function automatic logic [39:0] crc_msg(input t_hdr hd);
        logic [31:0] s;
        logic [31:0] n;
        s = 32'(hd.size);
        n = 32'(hd.nxt);
        return {s[7:0], s[15:8], n[7:0], n[15:8], hd.attr};
    endfunction

    t_state                r_state, n_state;
    t_state                r_ret, n_ret;
    t_req_type             r_rt, n_rt;
    logic [HANDLE_W-1:0]   r_h, n_h;
    logic [REQ_W-1:0]      r_rq, n_rq;
    logic [AW-1:0]         r_b, n_b;
    logic [AW-1:0]         r_cur, n_cur;
    logic [AW:0]           r_steps, n_steps;
    t_hdr                  r_hb, n_hb;
    t_hdr                  r_hj, n_hj;
    t_hdr                  r_hn, n_hn;
    logic [XW-1:0]         r_wrap, n_wrap;
    logic                  r_crc_go, n_crc_go;
    logic                  r_move, n_move;
    t_status               r_st, n_st;
    logic [HANDLE_W-1:0]   r_rh, n_rh;
    logic [HANDLE_W-1:0]   r_cd, n_cd;
    logic                  r_cv, n_cv;
    logic [THR_W-1:0]      r_thr;
    logic                  r_out_valid;
    logic                  out_load;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    t_hdr                  mem_wdata;
    logic [AW-1:0]         mem_raddr;
    t_hdr                  d;
    t_crc_rsp              crc_rsp;

    // Datapath terms, taken from the request, the header just read or held registers.
    logic [XW-1:0]  hx;
    logic           loc_bad;
    logic [SW-1:0]  rqs;
    logic [SW-1:0]  bs;
    logic           chk_fit;
    logic           chk_split;
    logic [XW-1:0]  nb_raw;
    logic [SW-1:0]  grow;
    logic           j_thr;
    logic           j_fit;
    logic [SW-1:0]  t_j;
    logic [SW-1:0]  t_hj;
    logic [XW-1:0]  ns_raw;
    logic [XW-1:0]  i_plus_h;
    logic [AW:0]    steps_inc;

    assign hx        = XW'(i_handle);
    assign loc_bad   = (hx < HB) || ((hx - HB) >= PB);
    assign rqs       = SW'(r_rq);
    assign bs        = r_hb.size;
    assign chk_fit   = !d.attr[0] && (d.size >= rqs);
    assign chk_split = XW'(d.size) >= (XW'(r_rq) + HB + XW'(r_thr));
    assign nb_raw    = XW'(r_cur) + HB + XW'(r_rq);
    assign grow      = rqs - bs;
    assign j_thr     = XW'(d.size) >= (XW'(grow) + XW'(r_thr));
    assign j_fit     = d.size >= grow;
    assign t_j       = d.size - grow;
    assign t_hj      = r_hj.size - grow;
    assign ns_raw    = XW'(r_hb.nxt) + XW'(grow);
    assign i_plus_h  = XW'(r_cur) + HB;
    assign steps_inc = r_steps + 1'b1;

    ffha_mem #(
        .DEPTH(POOL_BYTES),
        .WIDTH(HW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (d)
    );

    ffha_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_crc_go),
        .i_msg   (crc_msg(r_hn)),
        .o_rsp   (crc_rsp)
    );

    assign o_req_ready = (r_state == S_IDLE);
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_rsp_ready);

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_rt      = r_rt;
        n_h       = r_h;
        n_rq      = r_rq;
        n_b       = r_b;
        n_cur     = r_cur;
        n_steps   = r_steps;
        n_hb      = r_hb;
        n_hj      = r_hj;
        n_hn      = r_hn;
        n_wrap    = r_wrap;
        n_crc_go  = 1'b0;
        n_move    = r_move;
        n_st      = r_st;
        n_rh      = r_rh;
        n_cd      = r_cd;
        n_cv      = r_cv;
        mem_we    = 1'b0;
        mem_waddr = r_cur;
        mem_wdata = r_hn;
        mem_raddr = r_cur;

        case (r_state)
            S_INIT: begin
                // The head block covers the whole pool after reset.
                mem_we         = 1'b1;
                mem_waddr      = '0;
                mem_wdata.size = SW'(POOL_BYTES - HEADER_BYTES);
                mem_wdata.nxt  = '0;
                mem_wdata.attr = 8'h00;
                mem_wdata.crc  = INIT_CRC;
                n_state        = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_rt    = t_req_type'(i_req_type);
                    n_h     = i_handle;
                    n_rq    = i_req_size;
                    n_b     = AW'(hx - HB);
                    n_rh    = '0;
                    n_cd    = '0;
                    n_cv    = 1'b0;
                    n_move  = 1'b0;
                    n_cur   = '0;
                    n_steps = '0;
                    n_state = S_DONE;
                    case (t_req_type'(i_req_type))
                        REQ_ALLOC: begin
                            if (i_req_size == '0) begin
                                n_st = ST_NULL;
                            end else begin
                                n_state = S_A_ISS;
                            end
                        end
                        REQ_FREE, REQ_RESIZE: begin
                            if (i_handle == '0) begin
                                n_st = ST_NULL;
                            end else if (loc_bad) begin
                                n_st = ST_FAULT;
                            end else begin
                                mem_raddr = AW'(hx - HB);
                                n_state   = S_L_DAT;
                            end
                        end
                        default: begin
                            n_st = ST_NULL;
                        end
                    endcase
                end
            end
            S_L_DAT: begin
                n_hb     = d;
                n_hn     = d;
                n_crc_go = 1'b1;
                n_state  = S_L_CRC;
            end
            S_L_CRC: begin
                if (crc_rsp.done) begin
                    if (crc_rsp.value != r_hb.crc) begin
                        n_st    = ST_FAULT;
                        n_state = S_DONE;
                    end else if (r_rt == REQ_FREE) begin
                        n_st    = ST_OK;
                        n_state = S_F_RD;
                    end else begin
                        n_state = S_R_EVAL;
                    end
                end
            end
            S_R_EVAL: begin
                n_state = S_R_MOVE;
                if (r_hb.attr[1]) begin
                    if ((XW'(r_rq) + XW'(r_hb.attr[7:2])) < XW'(bs)) begin
                        n_st    = ST_SHRINK;
                        n_state = S_DONE;
                    end else if (bs >= rqs) begin
                        n_hn.size = bs;
                        n_hn.nxt  = r_hb.nxt;
                        n_hn.attr = set_slack(r_hb.attr, bs != rqs, 6'(bs - rqs));
                        n_hn.crc  = 8'h00;
                        n_crc_go  = 1'b1;
                        n_state   = S_R_CW;
                    end else if (r_hb.nxt != '0) begin
                        mem_raddr = r_hb.nxt;
                        n_state   = S_R_J;
                    end
                end else if (rqs < bs) begin
                    n_st    = ST_SHRINK;
                    n_state = S_DONE;
                end else if (r_hb.nxt != '0) begin
                    mem_raddr = r_hb.nxt;
                    n_state   = S_R_J;
                end
            end
            S_R_J: begin
                n_state = S_R_MOVE;
                if (!d.attr[0]) begin
                    if (j_thr) begin
                        // Shift the following free header up by the growth.
                        n_hj    = d;
                        n_wrap  = ns_raw;
                        n_ret   = S_R_SH;
                        n_state = S_WRAP;
                    end else if (j_fit) begin
                        // Absorb the following block whole; excess is slack.
                        n_hn.size = bs + d.size + SW'(HEADER_BYTES);
                        n_hn.nxt  = d.nxt;
                        n_hn.attr = set_slack(r_hb.attr, 1'b1, 6'(t_j + SW'(HEADER_BYTES)));
                        n_hn.crc  = 8'h00;
                        n_crc_go  = 1'b1;
                        n_state   = S_R_CW;
                    end
                end
            end
            S_R_SH: begin
                mem_we         = 1'b1;
                mem_waddr      = r_wrap[AW-1:0];
                mem_wdata.size = t_hj;
                mem_wdata.nxt  = r_hj.nxt;
                mem_wdata.attr = r_hj.attr;
                mem_wdata.crc  = r_hj.crc;
                n_hn.size      = rqs;
                n_hn.nxt       = r_wrap[AW-1:0];
                n_hn.attr      = r_hb.attr & ~ATTR_SLACK;
                n_hn.crc       = 8'h00;
                n_crc_go       = 1'b1;
                n_state        = S_R_CW;
            end
            S_R_CW: begin
                if (crc_rsp.done) begin
                    mem_we        = 1'b1;
                    mem_waddr     = r_b;
                    mem_wdata     = r_hn;
                    mem_wdata.crc = crc_rsp.value;
                    n_st          = ST_OK;
                    n_rh          = r_h;
                    n_state       = S_DONE;
                end
            end
            S_R_MOVE: begin
                if (r_rq == '0) begin
                    n_st    = ST_NULL;
                    n_state = S_DONE;
                end else begin
                    n_move  = 1'b1;
                    n_cur   = '0;
                    n_steps = '0;
                    n_state = S_A_ISS;
                end
            end
            S_A_ISS: begin
                mem_raddr = r_cur;
                n_state   = S_A_CHK;
            end
            S_A_CHK: begin
                if (chk_fit) begin
                    n_hj = d;
                    if (chk_split) begin
                        n_wrap  = nb_raw;
                        n_ret   = S_A_SPL;
                        n_state = S_WRAP;
                    end else begin
                        n_hn.size = d.size;
                        n_hn.nxt  = d.nxt;
                        n_hn.attr = set_slack(d.attr, 1'b1, 6'(d.size - rqs)) | ATTR_USED;
                        n_hn.crc  = 8'h00;
                        n_crc_go  = 1'b1;
                        n_state   = S_A_C2;
                    end
                end else if ((d.nxt == '0) || (steps_inc == PSTEPS)) begin
                    n_st    = ST_NOSPACE;
                    n_state = S_DONE;
                end else begin
                    n_cur     = d.nxt;
                    n_steps   = steps_inc;
                    mem_raddr = d.nxt;
                end
            end
            S_A_SPL: begin
                n_hn.size = r_hj.size - rqs - SW'(HEADER_BYTES);
                n_hn.nxt  = r_hj.nxt;
                n_hn.attr = 8'h00;
                n_hn.crc  = 8'h00;
                n_crc_go  = 1'b1;
                n_state   = S_A_C1;
            end
            S_A_C1: begin
                if (crc_rsp.done) begin
                    // A freshly split header keeps an inverted check byte.
                    mem_we        = 1'b1;
                    mem_waddr     = r_wrap[AW-1:0];
                    mem_wdata     = r_hn;
                    mem_wdata.crc = ~crc_rsp.value;
                    n_hn.size     = rqs;
                    n_hn.nxt      = r_wrap[AW-1:0];
                    n_hn.attr     = (r_hj.attr & ~ATTR_SLACK) | ATTR_USED;
                    n_hn.crc      = 8'h00;
                    n_crc_go      = 1'b1;
                    n_state       = S_A_C2;
                end
            end
            S_A_C2: begin
                if (crc_rsp.done) begin
                    mem_we        = 1'b1;
                    mem_waddr     = r_cur;
                    mem_wdata     = r_hn;
                    mem_wdata.crc = crc_rsp.value;
                    n_st          = ST_OK;
                    n_rh          = i_plus_h[HANDLE_W-1:0];
                    if (r_move) begin
                        n_cv    = 1'b1;
                        n_cd    = i_plus_h[HANDLE_W-1:0];
                        n_state = S_F_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_F_RD: begin
                mem_raddr = r_b;
                n_state   = S_F_MOD;
            end
            S_F_MOD: begin
                mem_we         = 1'b1;
                mem_waddr      = r_b;
                mem_wdata      = d;
                mem_wdata.attr = d.attr & ~ATTR_USED;
                n_state        = S_F_W0;
            end
            S_F_W0: begin
                mem_raddr = '0;
                n_cur     = '0;
                n_steps   = '0;
                n_state   = S_F_I;
            end
            S_F_I: begin
                n_hj = d;
                if (d.nxt == '0) begin
                    n_state = S_DONE;
                end else begin
                    mem_raddr = d.nxt;
                    n_state   = S_F_J;
                end
            end
            S_F_J: begin
                if (!r_hj.attr[0] && !d.attr[0]) begin
                    // Merge the first free pair; the stored check byte stays.
                    mem_we         = 1'b1;
                    mem_waddr      = r_cur;
                    mem_wdata.size = r_hj.size + d.size + SW'(HEADER_BYTES);
                    mem_wdata.nxt  = d.nxt;
                    mem_wdata.attr = r_hj.attr;
                    mem_wdata.crc  = r_hj.crc;
                    n_state        = S_DONE;
                end else begin
                    n_cur   = r_hj.nxt;
                    n_hj    = d;
                    n_steps = steps_inc;
                    if ((steps_inc == PSTEPS) || (d.nxt == '0)) begin
                        n_state = S_DONE;
                    end else begin
                        mem_raddr = d.nxt;
                    end
                end
            end
            S_WRAP: begin
                if (r_wrap >= PB) begin
                    n_wrap = r_wrap - PB;
                end else begin
                    n_state = r_ret;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_ret       <= S_IDLE;
            r_crc_go    <= 1'b0;
            r_thr       <= THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_crc_go <= n_crc_go;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rt    <= n_rt;
        r_h     <= n_h;
        r_rq    <= n_rq;
        r_b     <= n_b;
        r_cur   <= n_cur;
        r_steps <= n_steps;
        r_hb    <= n_hb;
        r_hj    <= n_hj;
        r_hn    <= n_hn;
        r_wrap  <= n_wrap;
        r_move  <= n_move;
        r_st    <= n_st;
        r_rh    <= n_rh;
        r_cd    <= n_cd;
        r_cv    <= n_cv;
        if (out_load) begin
            o_status        <= 3'(r_st);
            o_result_handle <= r_rh;
            o_copy_valid    <= r_cv;
            o_copy_src      <= r_cv ? r_h : '0;
            o_copy_dst      <= r_cd;
            o_copy_len      <= r_cv ? bs[REQ_W-1:0] : '0;
        end
    end

    assign o_rsp_valid = r_out_valid;

    // A copy command only ever accompanies a successful move.
    a_copy_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_copy_valid |-> o_status == 3'(ST_OK))
        else $error("copy command with non-ok status");

    // The header store is never written while waiting for a request.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("header write while idle");

    // A new response appears only out of the completion state.
    a_rsp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(r_state == S_DONE))
        else $error("response raised outside completion");

    // A checksum is started only from states that then wait for it.
    a_crc_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_crc_go |-> (r_state == S_L_CRC) || (r_state == S_R_CW) ||
                     (r_state == S_A_C1) || (r_state == S_A_C2))
        else $error("checksum started with no consumer");

endmodule

`default_nettype wire

### src/ffha_crc.sv
// Byte-serial CRC-8 unit for block headers: five bytes, one per cycle.
// Depends on ffha_pkg for the per-byte step and the response struct.
`default_nettype none

module ffha_crc
    import ffha_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [39:0] i_msg,
    output t_crc_rsp         o_rsp
);

    logic [39:0] r_buf;
    logic [7:0]  r_crc;
    logic [2:0]  r_cnt;
    logic        r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 3'd1) && !i_start;
            if (i_start) begin
                r_cnt <= 3'd5;
            end else if (r_cnt != 3'd0) begin
                r_cnt <= r_cnt - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_buf <= i_msg;
            r_crc <= 8'h00;
        end else if (r_cnt != 3'd0) begin
            r_crc <= crc8_byte(r_crc, r_buf[39:32]);
            r_buf <= {r_buf[31:0], 8'h00};
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_crc;

endmodule

`default_nettype wire

### src/ffha_mem.sv
// Header store: one write port and one read port, read data registered.
// Depends on ffha_pkg for the default depth; it has no reset.
`default_nettype none

module ffha_mem
    import ffha_pkg::*;
#(
    parameter int DEPTH = POOL_BYTES_DEF,
    parameter int WIDTH = 42
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### tb/sv/first_fit_heap_allocator_unit_test.sv
// Self-checking testbench of the first-fit heap allocator unit.
// Depends on ffha_pkg and first_fit_heap_allocator_unit, and through it on ffha_mem and ffha_crc.
// A directed table is applied first, then random requests in eight
// split-threshold phases, checked against an in-bench heap predictor or, for typed rows, against the table.
`default_nettype none

module first_fit_heap_allocator_unit_test;
    import ffha_pkg::*;

    localparam int POOL = POOL_BYTES_DEF;
    localparam int HDR  = HEADER_BYTES_DEF;

    // One response as the block reports it.
    typedef struct {
        logic [2:0]          status;
        logic [HANDLE_W-1:0] handle;
        logic                copy_valid;
        logic [HANDLE_W-1:0] copy_src;
        logic [HANDLE_W-1:0] copy_dst;
        logic [REQ_W-1:0]    copy_len;
    } heap_rsp_t;

    // One row of the directed table. When typed is set, the response is
    // known by inspection and is taken from the row instead of the predictor.
    typedef struct {
        t_req_type kind;
        int        hnd;
        int        sz;
        bit        typed;
        t_status   st;
        int        rh;
    } plan_row_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [THR_W-1:0]    i_cfg_wdata;
    logic                i_req_valid;
    logic                o_req_ready;
    logic [1:0]          i_req_type;
    logic [HANDLE_W-1:0] i_handle;
    logic [REQ_W-1:0]    i_req_size;
    logic                o_rsp_valid;
    logic                i_rsp_ready;
    logic [2:0]          o_status;
    logic [HANDLE_W-1:0] o_result_handle;
    logic                o_copy_valid;
    logic [HANDLE_W-1:0] o_copy_src;
    logic [HANDLE_W-1:0] o_copy_dst;
    logic [REQ_W-1:0]    o_copy_len;

    first_fit_heap_allocator_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_req_valid     (i_req_valid),
        .o_req_ready     (o_req_ready),
        .i_req_type      (i_req_type),
        .i_handle        (i_handle),
        .i_req_size      (i_req_size),
        .o_rsp_valid     (o_rsp_valid),
        .i_rsp_ready     (i_rsp_ready),
        .o_status        (o_status),
        .o_result_handle (o_result_handle),
        .o_copy_valid    (o_copy_valid),
        .o_copy_src      (o_copy_src),
        .o_copy_dst      (o_copy_dst),
        .o_copy_len      (o_copy_len)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Shadow copy of the header store. Every entry the predictor writes is
    // remembered so that stale handles only ever point at written headers.
    int unsigned   blk_size [POOL];
    int unsigned   blk_next [POOL];
    bit [7:0]      blk_attr [POOL];
    bit [7:0]      blk_crc  [POOL];
    bit            blk_seen [POOL];
    int            seen_offsets[$];
    int            live_handles[$];
    int unsigned   split_thr;

    heap_rsp_t     pending_rsps[$];
    int            mismatches;
    bit            quiet_mode;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(string field, longint got, longint want);
        mismatches++;
        $display("MISMATCH %s: got %0d, expected %0d", field, got, want);
    endtask

    function automatic int wrap_off(longint off);
        return int'(off % POOL);
    endfunction

    function automatic void touch(int b);
        if (!blk_seen[b]) begin
            blk_seen[b] = 1'b1;
            seen_offsets.push_back(b);
        end
    endfunction

    // CRC-8, polynomial 0x07, fed bit-serially MSB first over size, next and
    // attribute bytes, low bytes first.
    function automatic bit [7:0] header_check(int b);
        bit [39:0] msg;
        bit [7:0]  c;
        bit        fb;
        msg = {blk_size[b][7:0], blk_size[b][15:8], blk_next[b][7:0],
               blk_next[b][15:8], blk_attr[b]};
        c = 8'h00;
        for (int i = 39; i >= 0; i--) begin
            fb = c[7] ^ msg[i];
            c = c << 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void put_slack(int b, bit flag, longint len);
        bit [7:0] a;
        a = blk_attr[b] & ATTR_USED;
        a = a | {len[5:0], 2'b00};
        if (flag) begin
            a = a | ATTR_SLACK;
        end
        blk_attr[b] = a;
    endfunction

    function automatic bit first_fit(int unsigned want, output int hdr);
        int     cur;
        longint rest;
        int     nb;
        cur = 0;
        hdr = 0;
        for (int steps = 0; steps < POOL; steps++) begin
            cur = wrap_off(cur);
            if (!(blk_attr[cur] & ATTR_USED) && blk_size[cur] >= want) begin
                rest = longint'(blk_size[cur]) - want - HDR;
                if (rest >= longint'(split_thr)) begin
                    nb = wrap_off(longint'(cur) + HDR + want);
                    touch(nb);
                    blk_size[nb] = int'(rest);
                    blk_next[nb] = blk_next[cur];
                    blk_attr[nb] = 8'h00;
                    blk_crc[nb]  = ~header_check(nb);
                    blk_size[cur] = want;
                    blk_next[cur] = nb;
                    blk_attr[cur] = blk_attr[cur] & ~ATTR_SLACK;
                end else begin
                    put_slack(cur, 1'b1, longint'(blk_size[cur]) - want);
                end
                blk_attr[cur] = blk_attr[cur] | ATTR_USED;
                blk_crc[cur] = header_check(cur);
                hdr = cur;
                return 1'b1;
            end
            if (blk_next[cur] == 0) begin
                return 1'b0;
            end
            cur = blk_next[cur];
        end
        return 1'b0;
    endfunction

    // Marks a block free, then merges the first free pair along the chain.
    function automatic void release_block(int b);
        int cur;
        int nx;
        blk_attr[b] = blk_attr[b] & ~ATTR_USED;
        cur = 0;
        for (int steps = 0; steps < POOL; steps++) begin
            cur = wrap_off(cur);
            nx = blk_next[cur];
            if (nx == 0) begin
                return;
            end
            if (!(blk_attr[cur] & ATTR_USED) && !(blk_attr[wrap_off(nx)] & ATTR_USED)) begin
                nx = wrap_off(nx);
                blk_size[cur] = blk_size[cur] + blk_size[nx] + HDR;
                blk_next[cur] = blk_next[nx];
                return;
            end
            cur = nx;
        end
    endfunction

    function automatic heap_rsp_t predict_heap(t_req_type kind, int h, int unsigned rq);
        heap_rsp_t r;
        int        b;
        int        nh;
        int        j;
        int        ns;
        int unsigned bs;
        bit [7:0]  at;
        bit        done;
        longint    sl;
        longint    t;
        longint    grow;
        r = '{ST_NULL, 0, 0, 0, 0, 0};
        if (kind == REQ_ALLOC) begin
            if (rq == 0) begin
                r.status = ST_NULL;
            end else if (first_fit(rq, nh)) begin
                r.status = ST_OK;
                r.handle = nh + HDR;
            end else begin
                r.status = ST_NOSPACE;
            end
        end else if (kind == REQ_FREE || kind == REQ_RESIZE) begin
            b = h - HDR;
            if (h == 0) begin
                r.status = ST_NULL;
            end else if (h < HDR || header_check(b) != blk_crc[b]) begin
                r.status = ST_FAULT;
            end else if (kind == REQ_FREE) begin
                release_block(b);
                r.status = ST_OK;
            end else begin
                bs = blk_size[b];
                at = blk_attr[b];
                done = 1'b0;
                if (at & ATTR_SLACK) begin
                    sl = (at >> 2) & 8'h3F;
                    t = longint'(bs) - rq;
                    if (longint'(rq) < longint'(bs) - sl) begin
                        r.status = ST_SHRINK;
                        done = 1'b1;
                    end else if (t >= 0) begin
                        put_slack(b, t != 0, t);
                        blk_crc[b] = header_check(b);
                        r.status = ST_OK;
                        r.handle = h;
                        done = 1'b1;
                    end
                end else if (rq < bs) begin
                    r.status = ST_SHRINK;
                    done = 1'b1;
                end
                // Grow into the following free block, moving its header up
                // when enough of it stays, or swallowing it whole if it still covers the growth.
                if (!done && blk_next[b] != 0 && !(blk_attr[wrap_off(blk_next[b])] & ATTR_USED))
                begin
                    j = wrap_off(blk_next[b]);
                    grow = longint'(rq) - bs;
                    t = longint'(blk_size[j]) - grow;
                    if (t >= longint'(split_thr)) begin
                        ns = wrap_off(longint'(j) + grow);
                        touch(ns);
                        blk_size[ns] = int'(t);
                        blk_next[ns] = blk_next[j];
                        blk_attr[ns] = blk_attr[j];
                        blk_crc[ns]  = blk_crc[j];
                        blk_size[b] = rq;
                        blk_next[b] = ns;
                        blk_attr[b] = blk_attr[b] & ~ATTR_SLACK;
                        blk_crc[b] = header_check(b);
                        r.status = ST_OK;
                        r.handle = h;
                        done = 1'b1;
                    end else if (t >= 0) begin
                        blk_next[b] = blk_next[j];
                        put_slack(b, 1'b1, t + HDR);
                        blk_size[b] = bs + blk_size[j] + HDR;
                        blk_crc[b] = header_check(b);
                        r.status = ST_OK;
                        r.handle = h;
                        done = 1'b1;
                    end
                end
                if (!done) begin
                    if (rq == 0) begin
                        r.status = ST_NULL;
                    end else if (!first_fit(rq, nh)) begin
                        r.status = ST_NOSPACE;
                    end else begin
                        r.copy_valid = 1'b1;
                        r.copy_src = h;
                        r.copy_dst = nh + HDR;
                        r.copy_len = bs;
                        release_block(b);
                        r.status = ST_OK;
                        r.handle = nh + HDR;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic void drop_live(int h);
        foreach (live_handles[k]) begin
            if (live_handles[k] == h) begin
                live_handles.delete(k);
                return;
            end
        end
    endfunction

    // Predicts one accepted request and keeps the list of live handles.
    function automatic heap_rsp_t account_request(t_req_type kind, int h, int unsigned rq);
        heap_rsp_t r;
        r = predict_heap(kind, h, rq);
        if (r.status == ST_OK) begin
            if (kind == REQ_ALLOC) begin
                live_handles.push_back(r.handle);
            end else if (kind == REQ_FREE) begin
                drop_live(h);
            end else if (r.copy_valid) begin
                drop_live(h);
                live_handles.push_back(r.handle);
            end
        end
        return r;
    endfunction

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int gap_cycles();
        int p;
        if (quiet_mode) begin
            return 0;
        end
        p = $urandom_range(99);
        if (p < 65) begin
            return 0;
        end else if (p < 94) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(60, 10);
    endfunction

    // Presents one request and holds it until accepted. The response is
    // predicted at the acceptance edge; valid drops only if a gap follows.
    task automatic send_request(t_req_type kind, int h, int unsigned rq, bit typed,
                                heap_rsp_t want);
        heap_rsp_t r;
        int        gap;
        i_req_valid <= 1'b1;
        i_req_type  <= kind;
        i_handle    <= h[HANDLE_W-1:0];
        i_req_size  <= rq[REQ_W-1:0];
        @(posedge i_clk);
        while (!o_req_ready) begin
            @(posedge i_clk);
        end
        r = account_request(kind, h, rq);
        pending_rsps.push_back(typed ? want : r);
        gap = gap_cycles();
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Lets every expected response drain, then writes the threshold.
    task automatic write_threshold(int unsigned value);
        i_req_valid <= 1'b0;
        while (pending_rsps.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[THR_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        split_thr = value;
        @(posedge i_clk);
    endtask

    // Random request: mostly allocations, frees and resizes of live blocks,
    // with a share of malformed or stale requests.
    task automatic send_random();
        int          p;
        int          h;
        int unsigned rq;
        t_req_type   kind;
        heap_rsp_t   none;
        none = '{ST_OK, 0, 0, 0, 0, 0};
        p = $urandom_range(99);
        h = 0;
        rq = 0;
        if (p < 36 || (p < 90 && live_handles.size() == 0)) begin
            kind = REQ_ALLOC;
            case ($urandom_range(19))
                0: rq = 0;
                1: rq = $urandom_range(8191);
                2: rq = $urandom_range(4096, 1000);
                default: rq = $urandom_range(200, 1);
            endcase
        end else if (p < 66) begin
            kind = REQ_FREE;
            h = live_handles[$urandom_range(live_handles.size() - 1)];
        end else if (p < 90) begin
            kind = REQ_RESIZE;
            h = live_handles[$urandom_range(live_handles.size() - 1)];
            rq = blk_size[h - HDR];
            case ($urandom_range(9))
                0: rq = $urandom_range(8191);
                1: rq = (rq > 0) ? rq - 1 : 0;
                2: rq = rq + $urandom_range(600, 64);
                default: rq = rq + $urandom_range(40);
            endcase
        end else begin
            kind = ($urandom_range(1) != 0) ? REQ_FREE : REQ_RESIZE;
            rq = $urandom_range(8191);
            case ($urandom_range(3))
                0: kind = REQ_BAD;
                1: h = 0;
                2: h = $urandom_range(HDR - 1, 1);
                default: begin
                    // A header offset that was written at some point.
                    h = seen_offsets[$urandom_range(seen_offsets.size() - 1)] + HDR;
                    if (h >= POOL) begin
                        h = HDR;
                    end
                end
            endcase
            if (kind == REQ_BAD) begin
                h = $urandom_range(4095);
            end
        end
        send_request(kind, h, rq, 1'b0, none);
    endtask

    // Response side: random back-pressure and the field-by-field check.
    int stall_left;
    always @(posedge i_clk) begin
        heap_rsp_t want;
        if (o_rsp_valid && i_rsp_ready && i_rst_n) begin
            if (pending_rsps.size() == 0) begin
                report_mismatch("unexpected response, status", o_status, 0);
            end else begin
                want = pending_rsps.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch("status", o_status, want.status);
                end
                if (o_result_handle !== want.handle) begin
                    report_mismatch("result_handle", o_result_handle, want.handle);
                end
                if (o_copy_valid !== want.copy_valid) begin
                    report_mismatch("copy_valid", o_copy_valid, want.copy_valid);
                end
                if (o_copy_src !== want.copy_src) begin
                    report_mismatch("copy_src", o_copy_src, want.copy_src);
                end
                if (o_copy_dst !== want.copy_dst) begin
                    report_mismatch("copy_dst", o_copy_dst, want.copy_dst);
                end
                if (o_copy_len !== want.copy_len) begin
                    report_mismatch("copy_len", o_copy_len, want.copy_len);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_rsp_ready <= 1'b0;
        end else if (gap_cycles() > 0 && $urandom_range(1) != 0) begin
            stall_left <= gap_cycles();
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= 1'b1;
        end
    end

    // Overall limit, far above the slowest legal run.
    initial begin
        #200_000_000;
        $display("first_fit_heap_allocator_unit test failed");
        $finish;
    end

    initial begin
        plan_row_t   plan[$];
        heap_rsp_t   want;
        int unsigned phase_thr[8];
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_req_valid = 1'b0;
        i_req_type  = REQ_ALLOC;
        i_handle    = '0;
        i_req_size  = '0;
        i_rsp_ready = 1'b0;
        stall_left  = 0;
        mismatches  = 0;
        quiet_mode  = 1'b0;

        // Predictor reset: one free head block spanning the pool.
        for (int i = 0; i < POOL; i++) begin
            blk_size[i] = 0;
            blk_next[i] = 0;
            blk_attr[i] = 8'h00;
            blk_crc[i]  = 8'h00;
            blk_seen[i] = 1'b0;
        end
        touch(0);
        blk_size[0] = POOL - HDR;
        blk_crc[0] = header_check(0);
        split_thr = THR_RESET;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: the first rows follow from a fresh pool directly,
        // including the double free that faults on the stale check byte.
        plan.push_back('{REQ_ALLOC,   0,  100, 1, ST_OK,      12});
        plan.push_back('{REQ_BAD,     0,    0, 1, ST_NULL,     0});
        plan.push_back('{REQ_ALLOC,   0,    0, 1, ST_NULL,     0});
        plan.push_back('{REQ_FREE,    0,    0, 1, ST_NULL,     0});
        plan.push_back('{REQ_RESIZE,  0,   64, 1, ST_NULL,     0});
        plan.push_back('{REQ_FREE,    5,    0, 1, ST_FAULT,    0});
        plan.push_back('{REQ_ALLOC,   0, 8191, 1, ST_NOSPACE,  0});
        plan.push_back('{REQ_RESIZE, 12,   50, 1, ST_SHRINK,   0});
        plan.push_back('{REQ_FREE,   12,    0, 1, ST_OK,       0});
        plan.push_back('{REQ_FREE,   12,    0, 1, ST_FAULT,    0});
        plan.push_back('{REQ_ALLOC,   0, 4084, 1, ST_OK,      12});
        plan.push_back('{REQ_RESIZE, 12, 4084, 0, ST_OK,       0});
        plan.push_back('{REQ_FREE,   12,    0, 0, ST_OK,       0});
        plan.push_back('{REQ_ALLOC,   0,   20, 0, ST_OK,       0});
        plan.push_back('{REQ_ALLOC,   0,   30, 0, ST_OK,       0});
        plan.push_back('{REQ_ALLOC,   0,   40, 0, ST_OK,       0});
        plan.push_back('{REQ_RESIZE, 12,   25, 0, ST_OK,       0});
        plan.push_back('{REQ_FREE,   44,    0, 0, ST_OK,       0});
        plan.push_back('{REQ_RESIZE, 86,   60, 0, ST_OK,       0});
        plan.push_back('{REQ_RESIZE, 86,   63, 0, ST_OK,       0});
        plan.push_back('{REQ_ALLOC,   0, 4096, 0, ST_OK,       0});
        plan.push_back('{REQ_ALLOC,   0, 3900, 0, ST_OK,       0});
        foreach (plan[k]) begin
            want = '{plan[k].st, plan[k].rh, 0, 0, 0, 0};
            send_request(plan[k].kind, plan[k].hnd, plan[k].sz, plan[k].typed, want);
        end

        // Random part in phases; the first ones cover the threshold extremes.
        phase_thr = '{15, 1, 0, 4, 8, 0, 0, 0};
        for (int ph = 5; ph < 8; ph++) begin
            phase_thr[ph] = $urandom_range(15);
        end
        for (int ph = 0; ph < 8; ph++) begin
            write_threshold(phase_thr[ph]);
            quiet_mode = (ph == 3);
            for (int n = 0; n < 250; n++) begin
                send_random();
            end
        end
        i_req_valid <= 1'b0;
        quiet_mode = 1'b1;

        while (pending_rsps.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("first_fit_heap_allocator_unit test passed");
        end else begin
            $display("first_fit_heap_allocator_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
src/ffha_pkg.sv
src/ffha_crc.sv
src/ffha_mem.sv
src/first_fit_heap_allocator_unit.sv
tb/sv/first_fit_heap_allocator_unit_test.sv
